### sv/mqsm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsm_pkg
// Shared types and constants for the multi-queue slot manager.
// ----------------------------------------------------------------------------
package mqsm_pkg;

  // Defaults for the top-level parameters
  localparam int QUEUE_COUNT_DEF     = 8;
  localparam int SLOTS_PER_QUEUE_DEF = 8;

  // Size of one message slot in bytes
  localparam int MESSAGE_BYTES = 64;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int QINDEX_W = 3;
  localparam int STATUS_W = 2;
  localparam int QID_W    = 3;
  localparam int OFFSET_W = 9;

  // Stream widths, padded to whole bytes
  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 16;

  typedef enum logic [OPCODE_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_PUT   = 2'd2,
    OP_GET   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_QUEUE = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_e;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_EXEC = 1'b1
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;  // capture the request on this transfer
    logic commit;   // execute the held request and load the result register
  } mqsm_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_busy; // result register holds a result that is not taken this cycle
  } mqsm_stat_t;

endpackage

### sv/multi_queue_slot_manager.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_slot_manager
// Slot bookkeeping for a pool of fixed-size message ring queues.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel: tuser carries the opcode (alloc,
//   free, put, get), tdata the queue index. Every request gives exactly one
//   result on the m_axis channel: tuser carries the status, tdata the queue
//   id claimed by alloc and the byte offset of the slot reserved by put or
//   released by get.
//   The request register holds the request after its transfer; once the
//   result register has room, the request executes against the per-queue
//   flip-flop state and loads the result register, and the controller
//   then returns to accept. A new request is not taken until the held one
//   has executed.
//   The result register decouples the sides: a new request is accepted
//   while a result still waits. If the receiver stalls, that request is
//   held until the result register frees, and s_axis_tready stays low.
//   Reset marks every queue free with zero count, head and tail; no
//   clearing pass is needed, requests are taken right after reset.
// ----------------------------------------------------------------------------
module multi_queue_slot_manager
  import mqsm_pkg::*;
#(
  parameter int QUEUE_COUNT     = QUEUE_COUNT_DEF,
  parameter int SLOTS_PER_QUEUE = SLOTS_PER_QUEUE_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // [2:0] queue_index, [7:3] zero
  input  logic [OPCODE_W-1:0]  s_axis_tuser,  // [1:0] opcode
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // [2:0] queue_id, [11:3] slot_offset,
                                              // [15:12] zero
  output logic [STATUS_W-1:0]  m_axis_tuser   // [1:0] status
);

  mqsm_cmd_t           cmd;
  mqsm_stat_t          stat;
  logic [STATUS_W-1:0] out_status;
  logic [QID_W-1:0]    out_qid;
  logic [OFFSET_W-1:0] out_offset;

  mqsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  mqsm_dp #(
    .QUEUE_COUNT     (QUEUE_COUNT),
    .SLOTS_PER_QUEUE (SLOTS_PER_QUEUE)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .req_opcode_i (s_axis_tuser),
    .req_qindex_i (s_axis_tdata[QINDEX_W-1:0]),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_qid_o    (out_qid),
    .out_offset_o (out_offset)
  );

  // Pack the result fields
  assign m_axis_tuser = out_status;
  assign m_axis_tdata = {{(M_TDATA_W - QID_W - OFFSET_W){1'b0}}, out_offset, out_qid};

endmodule

### sv/mqsm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsm_ctrl
// Sequencer: takes one request, then executes it once the result register
// has room.
// ----------------------------------------------------------------------------
module mqsm_ctrl
  import mqsm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  output logic       req_ready_o,
  input  mqsm_stat_t stat_i,
  output mqsm_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CTRL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    req_ready_o   = 1'b0;
    cmd_o.load_in = 1'b0;
    cmd_o.commit  = 1'b0;
    unique case (state_q)
      CTRL_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = CTRL_EXEC;
        end
      end
      CTRL_EXEC: begin
        if (!stat_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = CTRL_IDLE;
        end
      end
      default: state_d = CTRL_IDLE;
    endcase
  end

endmodule

### sv/mqsm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqsm_dp
// Queue state, request register, execution logic and result register.
// ----------------------------------------------------------------------------
module mqsm_dp
  import mqsm_pkg::*;
#(
  parameter int QUEUE_COUNT     = QUEUE_COUNT_DEF,
  parameter int SLOTS_PER_QUEUE = SLOTS_PER_QUEUE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mqsm_cmd_t           cmd_i,
  output mqsm_stat_t          stat_o,
  input  logic [OPCODE_W-1:0] req_opcode_i,
  input  logic [QINDEX_W-1:0] req_qindex_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] out_status_o,
  output logic [QID_W-1:0]    out_qid_o,
  output logic [OFFSET_W-1:0] out_offset_o
);

  // Only queues reachable by the index field need pointers and counts
  localparam int AddrQueues = (QUEUE_COUNT < (1 << QINDEX_W)) ? QUEUE_COUNT
                                                              : (1 << QINDEX_W);
  localparam int QiW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int SlotW = (SLOTS_PER_QUEUE > 1) ? $clog2(SLOTS_PER_QUEUE) : 1;
  localparam int CntW  = $clog2(SLOTS_PER_QUEUE + 1);

  // Request register
  op_e                 op_q;
  logic [QINDEX_W-1:0] qidx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q   <= op_e'(req_opcode_i);
      qidx_q <= req_qindex_i;
    end
  end

  // Queue state
  logic [QUEUE_COUNT-1:0] in_use_q, in_use_d;
  logic [CntW-1:0]        cnt_q  [AddrQueues];
  logic [CntW-1:0]        cnt_d  [AddrQueues];
  logic [SlotW-1:0]       head_q [AddrQueues];
  logic [SlotW-1:0]       head_d [AddrQueues];
  logic [SlotW-1:0]       tail_q [AddrQueues];
  logic [SlotW-1:0]       tail_d [AddrQueues];

  // Result register
  logic                out_valid_q;
  status_e             status_q, status_d;
  logic [QID_W-1:0]    qid_q, qid_d;
  logic [OFFSET_W-1:0] off_q, off_d;

  // Read side of the addressed queue
  logic             q_valid;
  logic [CntW-1:0]  cnt_rd;
  logic [SlotW-1:0] head_rd, tail_rd;

  always_comb begin
    q_valid = 32'(qidx_q) < 32'(QUEUE_COUNT);
    cnt_rd  = '0;
    head_rd = '0;
    tail_rd = '0;
    for (int i = 0; i < AddrQueues; i++) begin
      if (q_valid && (32'(qidx_q) == 32'(i))) begin
        cnt_rd  = cnt_q[i];
        head_rd = head_q[i];
        tail_rd = tail_q[i];
      end
    end
  end

  // Lowest free queue
  logic           free_found;
  logic [QiW-1:0] free_idx;

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = QUEUE_COUNT - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_found = 1'b1;
        free_idx   = QiW'(i);
      end
    end
  end

  // Slot picked by put or get, its successor and byte offset
  logic             is_put;
  logic [SlotW-1:0] slot_sel, slot_next;
  logic [31:0]      slot_bytes;

  assign is_put     = (op_q == OP_PUT);
  assign slot_sel   = is_put ? tail_rd : head_rd;
  assign slot_next  = (slot_sel == SlotW'(SLOTS_PER_QUEUE - 1)) ? '0
                                                                : slot_sel + SlotW'(1);
  assign slot_bytes = 32'(slot_sel) * 32'(MESSAGE_BYTES);

  // Execute the held request
  always_comb begin
    in_use_d = in_use_q;
    cnt_d    = cnt_q;
    head_d   = head_q;
    tail_d   = tail_q;
    status_d = ST_OK;
    qid_d    = '0;
    off_d    = '0;
    unique case (op_q)
      OP_ALLOC: begin
        if (free_found) begin
          in_use_d[free_idx] = 1'b1;
          qid_d              = QID_W'(free_idx);
          for (int i = 0; i < AddrQueues; i++) begin
            if (32'(free_idx) == 32'(i)) begin
              cnt_d[i]  = '0;
              head_d[i] = '0;
              tail_d[i] = '0;
            end
          end
        end else begin
          status_d = ST_NO_QUEUE;
        end
      end
      OP_FREE: begin
        for (int i = 0; i < QUEUE_COUNT; i++) begin
          if (q_valid && (32'(qidx_q) == 32'(i))) begin
            in_use_d[i] = 1'b0;
          end
        end
      end
      OP_PUT: begin
        if (!q_valid || (cnt_rd == CntW'(SLOTS_PER_QUEUE))) begin
          status_d = ST_FULL;
        end else begin
          off_d = slot_bytes[OFFSET_W-1:0];
          for (int i = 0; i < AddrQueues; i++) begin
            if (32'(qidx_q) == 32'(i)) begin
              cnt_d[i]  = cnt_rd + CntW'(1);
              tail_d[i] = slot_next;
            end
          end
        end
      end
      OP_GET: begin
        if (!q_valid || (cnt_rd == '0)) begin
          status_d = ST_EMPTY;
        end else begin
          off_d = slot_bytes[OFFSET_W-1:0];
          for (int i = 0; i < AddrQueues; i++) begin
            if (32'(qidx_q) == 32'(i)) begin
              cnt_d[i]  = cnt_rd - CntW'(1);
              head_d[i] = slot_next;
            end
          end
        end
      end
      default: status_d = ST_OK;
    endcase
  end

  // State update on commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      for (int i = 0; i < AddrQueues; i++) begin
        cnt_q[i]  <= '0;
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else if (cmd_i.commit) begin
      in_use_q <= in_use_d;
      cnt_q    <= cnt_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q <= status_d;
      qid_q    <= qid_d;
      off_q    <= off_d;
    end
  end

  assign stat_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_status_o    = status_q;
  assign out_qid_o       = qid_q;
  assign out_offset_o    = off_q;

  // Checks
  a_commit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> !(out_valid_q && !out_ready_i))
    else $error("commit while result register still occupied");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |=> out_valid_q)
    else $error("committed result not presented");

  a_put_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_PUT) && (cnt_rd == CntW'(SLOTS_PER_QUEUE)))
      |=> (status_q == ST_FULL))
    else $error("put on full queue not reported");

  a_get_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.commit && (op_q == OP_GET) && (cnt_rd == '0)) |=> (status_q == ST_EMPTY))
    else $error("get on empty queue not reported");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-queue slot manager. Requests are driven
// on the slave stream, and a cycle-free model of the queue bookkeeping works
// out the expected status, queue id and slot offset of every transfer. Each
// result on the master stream is compared in order. Directed tests cover
// alloc exhaustion, full and empty queues, offset wrap and use of a freed
// queue. Random phases then vary the idling on both sides, and one phase
// stalls the output long enough to back up the input.
// ----------------------------------------------------------------------------
module tb;
  import mqsm_pkg::*;

  localparam int NUM_QUEUES  = QUEUE_COUNT_DEF;
  localparam int NUM_SLOTS   = SLOTS_PER_QUEUE_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    status_e              status;
    logic [QID_W-1:0]     queue_id;
    logic [OFFSET_W-1:0]  slot_offset;
  } slot_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;   // [2:0] queue_index, [7:3] zero
  logic [OPCODE_W-1:0]  s_axis_tuser;   // [1:0] opcode
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;   // [2:0] queue_id, [11:3] slot_offset, [15:12] zero
  logic [STATUS_W-1:0]  m_axis_tuser;   // [1:0] status

  multi_queue_slot_manager dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Queue bookkeeping as the block should hold it
  logic                      q_in_use [NUM_QUEUES];
  logic [3:0]                q_count  [NUM_QUEUES];
  logic [QINDEX_W-1:0]       q_head   [NUM_QUEUES];
  logic [QINDEX_W-1:0]       q_tail   [NUM_QUEUES];

  slot_result_t expected_results[$];

  int error_count;
  int request_count;
  int result_count;
  int status_seen[4];
  int cycle_count;

  // Idling knobs, changed between phases
  int send_idle_pct;
  int recv_stall_pct;
  int hold_request;
  int hold_left;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [QINDEX_W-1:0] next_slot(logic [QINDEX_W-1:0] s);
    return (int'(s) + 1 >= NUM_SLOTS) ? '0 : QINDEX_W'(int'(s) + 1);
  endfunction

  // Apply one request to the bookkeeping and return the result it gives
  function automatic slot_result_t predict_slot_op(op_e op, logic [QINDEX_W-1:0] q);
    slot_result_t r;
    logic         found;
    logic         q_ok;
    r.status      = ST_OK;
    r.queue_id    = '0;
    r.slot_offset = '0;
    found         = 1'b0;
    q_ok          = int'(q) < NUM_QUEUES;
    case (op)
      OP_ALLOC: begin
        r.status = ST_NO_QUEUE;
        for (int i = 0; i < NUM_QUEUES; i++) begin
          if (!found && !q_in_use[i]) begin
            found       = 1'b1;
            q_in_use[i] = 1'b1;
            q_count[i]  = '0;
            q_head[i]   = '0;
            q_tail[i]   = '0;
            r.status    = ST_OK;
            r.queue_id  = QID_W'(i);
          end
        end
      end
      OP_FREE: begin
        if (q_ok) q_in_use[q] = 1'b0;
      end
      OP_PUT: begin
        if (!q_ok || int'(q_count[q]) >= NUM_SLOTS) begin
          r.status = ST_FULL;
        end else begin
          q_count[q]    = q_count[q] + 1'b1;
          r.slot_offset = OFFSET_W'(int'(q_tail[q]) * MESSAGE_BYTES);
          q_tail[q]     = next_slot(q_tail[q]);
        end
      end
      default: begin
        if (!q_ok || q_count[q] == 0) begin
          r.status = ST_EMPTY;
        end else begin
          q_count[q]    = q_count[q] - 1'b1;
          r.slot_offset = OFFSET_W'(int'(q_head[q]) * MESSAGE_BYTES);
          q_head[q]     = next_slot(q_head[q]);
        end
      end
    endcase
    return r;
  endfunction

  // Offer one request, wait for its transfer, then record the expected result.
  // tvalid stays high afterwards; the next call idles or offers its own request, and the end lowers it.
  task automatic send_request(op_e op, logic [QINDEX_W-1:0] q);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(q);
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(predict_slot_op(op, q));
    request_count++;
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk_i) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    slot_result_t exp_r;
    status_e      act_status;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      act_status = status_e'(m_axis_tuser);
      result_count++;
      status_seen[m_axis_tuser]++;
      if (expected_results.size() == 0) begin
        error_count++;
        $error("result with nothing expected: status %0d", act_status);
      end else begin
        exp_r = expected_results.pop_front();
        if (act_status !== exp_r.status) begin
          error_count++;
          $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
        end
        if (m_axis_tdata[QID_W-1:0] !== exp_r.queue_id) begin
          error_count++;
          $error("queue_id: expected %0d, got %0d", exp_r.queue_id,
                 m_axis_tdata[QID_W-1:0]);
        end
        if (m_axis_tdata[QID_W +: OFFSET_W] !== exp_r.slot_offset) begin
          error_count++;
          $error("slot_offset: expected %0d, got %0d", exp_r.slot_offset,
                 m_axis_tdata[QID_W +: OFFSET_W]);
        end
      end
    end
  end

  // Pick a queue for free/put/get: mostly one in use, sometimes any index
  function automatic logic [QINDEX_W-1:0] pick_queue();
    int live[$];
    for (int i = 0; i < NUM_QUEUES; i++) if (q_in_use[i]) live.push_back(i);
    if (live.size() == 0 || $urandom_range(99) < 12) return QINDEX_W'($urandom_range(7));
    return QINDEX_W'(live[$urandom_range(live.size() - 1)]);
  endfunction

  // Random traffic; put and get weights swing so queues both fill and drain
  task automatic run_traffic(int n_items);
    int   r;
    int   put_pct;
    op_e  op;
    put_pct = 70;
    for (int k = 0; k < n_items; k++) begin
      if (k % 40 == 0) put_pct = (put_pct == 70) ? 30 : 70;
      r = $urandom_range(99);
      if (r < 4)        op = op_e'($urandom_range(3));
      else if (r < 12)  op = OP_ALLOC;
      else if (r < 19)  op = OP_FREE;
      else if ($urandom_range(99) < put_pct) op = OP_PUT;
      else              op = OP_GET;
      send_request(op, pick_queue());
    end
  endtask

  // Claim all queues, fail one more, then reuse a freed one
  task automatic test_alloc_exhaust();
    for (int i = 0; i < NUM_QUEUES + 1; i++) send_request(OP_ALLOC, (i % 2) ? 3'd7 : 3'd0);
    send_request(OP_FREE, 3'd5);
    send_request(OP_ALLOC, 3'd2);
  endtask

  // Fill a queue, overflow it, wrap the tail, and read an empty queue
  task automatic test_fill_and_wrap();
    for (int i = 0; i < NUM_SLOTS; i++) send_request(OP_PUT, 3'd7);
    send_request(OP_PUT, 3'd7);
    send_request(OP_GET, 3'd7);
    send_request(OP_PUT, 3'd7);
    send_request(OP_GET, 3'd0);
  endtask

  // Put and get still act on a queue after it is freed
  task automatic test_freed_queue();
    send_request(OP_FREE, 3'd2);
    send_request(OP_PUT, 3'd2);
    send_request(OP_GET, 3'd2);
  endtask

  task automatic test_random_phase(int n_items, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    run_traffic(n_items);
  endtask

  // Receiver holds off while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 300;
    run_traffic(200);
  endtask

  initial begin
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tuser   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = 0;
    hold_left      = 0;
    error_count    = 0;
    request_count  = 0;
    result_count   = 0;
    cycle_count    = 0;
    for (int i = 0; i < 4; i++) status_seen[i] = 0;
    for (int i = 0; i < NUM_QUEUES; i++) begin
      q_in_use[i] = 1'b0;
      q_count[i]  = '0;
      q_head[i]   = '0;
      q_tail[i]   = '0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_alloc_exhaust();
    test_fill_and_wrap();
    test_freed_queue();
    test_random_phase(500, 0, 0);
    test_random_phase(300, 84, 0);
    test_random_phase(300, 0, 84);
    test_random_phase(525, 19, 19);
    test_backpressure();

    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d results over %0d cycles.",
             request_count, result_count, cycle_count);
    $display("Status mix: ok %0d, no free queue %0d, full %0d, empty %0d.",
             status_seen[ST_OK], status_seen[ST_NO_QUEUE], status_seen[ST_FULL],
             status_seen[ST_EMPTY]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
